### hdl/vector3_arithmetic_unit_assert.svh
`ifndef VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
// implication check, disabled during reset
`define V3A_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define V3A_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hdl/v3au_pkg.sv
package v3au_pkg;
  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CMD_W = 3;
  localparam int THR_W = 16;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DOT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CROSS = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LEN  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NORM = 3'd5;
endpackage

### hdl/v3au_if.sv
interface v3au_in_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface v3au_out_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] out_x, out_y, out_z, scalar_out;
  logic saturated, degenerate;
  modport source (output valid, out_x, out_y, out_z, scalar_out, saturated, degenerate,
    input ready);
  modport sink (input valid, out_x, out_y, out_z, scalar_out, saturated, degenerate,
    output ready);
endinterface

### hdl/v3au_sat.sv
// clamps a wide signed value to CW bits
module v3au_sat #(
  parameter int WW = 128,
  parameter int CW = 32
) (
  input  logic signed [WW-1:0] din,
  output logic signed [CW-1:0] dout,
  output logic                 sat
);
  localparam logic signed [WW-1:0] MAXV = (WW'(1) <<< (CW-1)) - WW'(1);
  localparam logic signed [WW-1:0] MINV = -MAXV - WW'(1);
  always_comb begin
    sat  = 1'b0;
    dout = din[CW-1:0];
    if (din > MAXV) begin
      sat  = 1'b1;
      dout = MAXV[CW-1:0];
    end else if (din < MINV) begin
      sat  = 1'b1;
      dout = MINV[CW-1:0];
    end
  end
endmodule

### hdl/v3au_sqrt.sv
// pipelined restoring square root, one result bit per stage
module v3au_sqrt #(
  parameter int IW = 128,
  parameter int RW = 64,
  parameter int TW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] rad,
  input  logic [TW-1:0] tag_in,
  output logic [RW-1:0] root,
  output logic [TW-1:0] tag_out
);
  logic [IW-1:0] rem_r [RW+1];
  logic [RW-1:0] q_r   [RW+1];
  logic [TW-1:0] tag_r [RW+1];
  logic [IW+1:0] trial [RW];
  always_comb begin
    rem_r[0] = rad;
    q_r[0]   = '0;
    tag_r[0] = tag_in;
  end
  for (genvar i = 0; i < RW; i++) begin : g_st
    localparam int B = RW-1-i;
    // try root bit B: (2q + 2^B) * 2^B <= rem
    assign trial[i] = ({2'b0, IW'(q_r[i])} << (B+1)) + ((IW+2)'(1) << (2*B));
    logic [IW-1:0] rem_s;
    logic [RW-1:0] q_s;
    logic [TW-1:0] t_s;
    always_ff @(posedge clk) begin
      if (en) begin
        t_s <= tag_r[i];
        if (trial[i] <= {2'b0, rem_r[i]}) begin
          rem_s <= rem_r[i] - trial[i][IW-1:0];
          q_s   <= q_r[i] | (RW'(1) << B);
        end else begin
          rem_s <= rem_r[i];
          q_s   <= q_r[i];
        end
      end
    end
    assign rem_r[i+1] = rem_s;
    assign q_r[i+1]   = q_s;
    assign tag_r[i+1] = t_s;
  end
  assign root    = q_r[RW];
  assign tag_out = tag_r[RW];
endmodule

### hdl/v3au_div.sv
// pipelined restoring divider for three numerators sharing one divisor
module v3au_div #(
  parameter int NW = 128,
  parameter int DW = 64,
  parameter int TW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n0, n1, n2,
  input  logic [DW-1:0] d,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] q0, q1, q2,
  output logic [TW-1:0] tag_out
);
  logic [NW-1:0] n_r [3][NW+1];
  logic [DW:0]   r_r [3][NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic [TW-1:0] t_r [NW+1];
  assign n_r[0][0] = n0;
  assign n_r[1][0] = n1;
  assign n_r[2][0] = n2;
  assign r_r[0][0] = '0;
  assign r_r[1][0] = '0;
  assign r_r[2][0] = '0;
  assign d_r[0] = d;
  assign t_r[0] = tag_in;
  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW-1:0] d_s;
    logic [TW-1:0] t_s;
    always_ff @(posedge clk) begin
      if (en) begin
        d_s <= d_r[i];
        t_s <= t_r[i];
      end
    end
    assign d_r[i+1] = d_s;
    assign t_r[i+1] = t_s;
    for (genvar k = 0; k < 3; k++) begin : g_l
      logic [DW+1:0] sh;
      logic [NW-1:0] n_s;
      logic [DW:0]   r_s;
      // shift in numerator msb, quotient bit enters at lsb
      assign sh = {r_r[k][i], n_r[k][i][NW-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh >= {2'b0, d_r[i]}) begin
            r_s <= (DW+1)'(sh - {2'b0, d_r[i]});
            n_s <= {n_r[k][i][NW-2:0], 1'b1};
          end else begin
            r_s <= sh[DW:0];
            n_s <= {n_r[k][i][NW-2:0], 1'b0};
          end
        end
      end
      assign r_r[k][i+1] = r_s;
      assign n_r[k][i+1] = n_s;
    end
  end
  assign q0 = n_r[0][NW];
  assign q1 = n_r[1][NW];
  assign q2 = n_r[2][NW];
  assign tag_out = t_r[NW];
endmodule

### hdl/vector3_arithmetic_unit.sv
// vector3_arithmetic_unit: stateless Q16.16 three-vector alu
// input channel in (cmd, a_*, b_*) and result channel out, valid/ready each;
// a request is taken when valid and ready are high at a rising clk edge.
// cfg_we with cfg_wdata writes zero_threshold; write only while idle.
// every request takes the same path: two product/sum stages, a square root
// of COMP_WIDTH+1 stages, a divider of COMP_WIDTH+FRAC_BITS stages, then a
// result register. throughput is one request per cycle while the pipe is not
// held; the long path is set by the bit-per-stage square root and divider.
// when a result is pending at the end and out_ready is low the whole pipe holds;
// in_ready follows out_ready then, so nothing is lost or repeated.
// synchronous active-low reset clears valid bits and zero_threshold.
module vector3_arithmetic_unit #(
  parameter int COMP_WIDTH = v3au_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [v3au_pkg::THR_W-1:0] cfg_wdata,
  v3au_in_if.sink                 in_ch,
  v3au_out_if.source              out_ch
);
  import v3au_pkg::*;
  localparam int CW = COMP_WIDTH;
  localparam int PW = 2*CW + 3;          // sum of three products
  localparam int RW = CW + 1;            // root width
  localparam int NW = CW + FRAC_BITS;    // normalize numerator
  localparam int LAT = 2 + RW + NW;
  // tag: cmd, a_x..a_z, plus precomputed scalar/vector results and saturation flag
  localparam int TW = CMD_W + 3*CW + 4*CW + 1;

  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  logic en;
  logic [LAT:0] v_r;
  assign en = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  // stage 1: register inputs and products
  logic [CMD_W-1:0] cmd_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [2*CW-1:0] p_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= in_ch.cmd;
      ax_r <= in_ch.a_x; ay_r <= in_ch.a_y; az_r <= in_ch.a_z;
      bx_r <= in_ch.b_x; by_r <= in_ch.b_y; bz_r <= in_ch.b_z;
      p_r[0] <= in_ch.a_x * in_ch.b_x;
      p_r[1] <= in_ch.a_y * in_ch.b_y;
      p_r[2] <= in_ch.a_z * in_ch.b_z;
      p_r[3] <= in_ch.a_y * in_ch.b_z;
      p_r[4] <= in_ch.a_z * in_ch.b_y;
      p_r[5] <= in_ch.a_z * in_ch.b_x;
      p_r[6] <= in_ch.a_x * in_ch.b_z;
      p_r[7] <= in_ch.a_x * in_ch.b_y;
      p_r[8] <= in_ch.a_y * in_ch.b_x;
    end
  end
  logic signed [2*CW-1:0] sq_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= in_ch.a_x * in_ch.a_x;
      sq_r[1] <= in_ch.a_y * in_ch.a_y;
      sq_r[2] <= in_ch.a_z * in_ch.a_z;
    end
  end

  // stage 2: sums, shifts, clamps for simple ops
  logic signed [PW-1:0] dot_w, cx_w, cy_w, cz_w;
  logic signed [CW+1:0] s0, s1, s2;
  logic signed [CW-1:0] c0, c1, c2, c3;
  logic [3:0] st;
  logic sat_add;
  assign dot_w = (PW'(p_r[0]) + PW'(p_r[1]) + PW'(p_r[2])) >>> FRAC_BITS;
  assign cx_w  = (PW'(p_r[3]) - PW'(p_r[4])) >>> FRAC_BITS;
  assign cy_w  = (PW'(p_r[5]) - PW'(p_r[6])) >>> FRAC_BITS;
  assign cz_w  = (PW'(p_r[7]) - PW'(p_r[8])) >>> FRAC_BITS;
  always_comb begin
    if (cmd_r == CMD_SUB) begin
      s0 = (CW+2)'(ax_r) - (CW+2)'(bx_r);
      s1 = (CW+2)'(ay_r) - (CW+2)'(by_r);
      s2 = (CW+2)'(az_r) - (CW+2)'(bz_r);
    end else begin
      s0 = (CW+2)'(ax_r) + (CW+2)'(bx_r);
      s1 = (CW+2)'(ay_r) + (CW+2)'(by_r);
      s2 = (CW+2)'(az_r) + (CW+2)'(bz_r);
    end
  end
  logic signed [PW-1:0] m0, m1, m2, m3;
  always_comb begin
    m0 = '0; m1 = '0; m2 = '0; m3 = '0;
    unique case (cmd_r)
      CMD_ADD, CMD_SUB: begin
        m0 = PW'(s0); m1 = PW'(s1); m2 = PW'(s2);
      end
      CMD_DOT:   m3 = dot_w;
      CMD_CROSS: begin
        m0 = cx_w; m1 = cy_w; m2 = cz_w;
      end
      default: ;
    endcase
  end
  v3au_sat #(.WW(PW), .CW(CW)) u_s0 (.din(m0), .dout(c0), .sat(st[0]));
  v3au_sat #(.WW(PW), .CW(CW)) u_s1 (.din(m1), .dout(c1), .sat(st[1]));
  v3au_sat #(.WW(PW), .CW(CW)) u_s2 (.din(m2), .dout(c2), .sat(st[2]));
  v3au_sat #(.WW(PW), .CW(CW)) u_s3 (.din(m3), .dout(c3), .sat(st[3]));
  assign sat_add = |st;

  logic [2*RW-1:0] rad_r;
  logic [TW-1:0] tag2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= (2*RW)'(sq_r[0]) + (2*RW)'(sq_r[1]) + (2*RW)'(sq_r[2]);
      tag2_r <= {cmd_r, ax_r, ay_r, az_r, c0, c1, c2, c3, sat_add};
    end
  end

  // square root
  logic [RW-1:0] len_w;
  logic [TW-1:0] tag3;
  v3au_sqrt #(.IW(2*RW), .RW(RW), .TW(TW)) u_sqrt (
    .clk(clk), .en(en), .rad(rad_r), .tag_in(tag2_r), .root(len_w), .tag_out(tag3));

  logic signed [CW-1:0] ax3, ay3, az3;
  logic [CW-1:0] ma0, ma1, ma2;
  assign ax3 = tag3[TW-4 -: CW];
  assign ay3 = tag3[TW-4-CW -: CW];
  assign az3 = tag3[TW-4-2*CW -: CW];
  assign ma0 = ax3[CW-1] ? CW'(-ax3) : CW'(ax3);
  assign ma1 = ay3[CW-1] ? CW'(-ay3) : CW'(ay3);
  assign ma2 = az3[CW-1] ? CW'(-az3) : CW'(az3);

  // divider carries length in its tag for the final stage
  localparam int T2 = TW + RW;
  logic [NW-1:0] q0, q1, q2;
  logic [T2-1:0] tag4;
  logic [RW-1:0] dd;
  assign dd = (len_w == '0) ? RW'(1) : len_w;
  v3au_div #(.NW(NW), .DW(RW), .TW(T2)) u_div (
    .clk(clk), .en(en),
    .n0(NW'(ma0) << FRAC_BITS), .n1(NW'(ma1) << FRAC_BITS), .n2(NW'(ma2) << FRAC_BITS),
    .d(dd), .tag_in({len_w, tag3}), .q0(q0), .q1(q1), .q2(q2), .tag_out(tag4));

  // final stage
  logic [RW-1:0] len4;
  logic [CMD_W-1:0] cmd4;
  logic signed [CW-1:0] ax4, ay4, az4, fx, fy, fz, fs, nx, ny, nz, ls;
  logic fsat, fdeg, ns0, ns1, ns2, lsat;
  logic signed [NW+1:0] sq0, sq1, sq2;
  assign len4 = tag4[T2-1 -: RW];
  assign cmd4 = tag4[TW-1 -: CMD_W];
  assign ax4 = tag4[TW-4 -: CW];
  assign ay4 = tag4[TW-4-CW -: CW];
  assign az4 = tag4[TW-4-2*CW -: CW];
  assign sq0 = ax4[CW-1] ? -(NW+2)'(q0) : (NW+2)'(q0);
  assign sq1 = ay4[CW-1] ? -(NW+2)'(q1) : (NW+2)'(q1);
  assign sq2 = az4[CW-1] ? -(NW+2)'(q2) : (NW+2)'(q2);
  v3au_sat #(.WW(NW+2), .CW(CW)) u_n0 (.din(sq0), .dout(nx), .sat(ns0));
  v3au_sat #(.WW(NW+2), .CW(CW)) u_n1 (.din(sq1), .dout(ny), .sat(ns1));
  v3au_sat #(.WW(NW+2), .CW(CW)) u_n2 (.din(sq2), .dout(nz), .sat(ns2));
  v3au_sat #(.WW(RW+1), .CW(CW)) u_l (.din({1'b0, len4}), .dout(ls), .sat(lsat));
  always_comb begin
    fx = tag4[4*CW -: CW];
    fy = tag4[3*CW -: CW];
    fz = tag4[2*CW -: CW];
    fs = tag4[CW -: CW];
    fsat = tag4[0];
    fdeg = 1'b0;
    if (cmd4 == CMD_LEN) begin
      fs = ls; fsat = lsat;
    end else if (cmd4 == CMD_NORM) begin
      fs = '0;
      if ({{(THR_W){1'b0}}, len4} <= {{(RW){1'b0}}, thr_r}) begin
        fx = '0; fy = '0; fz = '0; fsat = 1'b0; fdeg = 1'b1;
      end else begin
        fx = nx; fy = ny; fz = nz; fsat = ns0 | ns1 | ns2;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.out_x <= fx; out_ch.out_y <= fy; out_ch.out_z <= fz;
      out_ch.scalar_out <= fs; out_ch.saturated <= fsat; out_ch.degenerate <= fdeg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-1:0], in_ch.valid};
  end
  assign out_ch.valid = v_r[LAT];
endmodule

### hdl/v3au_checker.sv
module v3au_checker #(
  parameter int CW = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [CW-1:0] out_x,
  input logic [CW-1:0] out_y,
  input logic [CW-1:0] out_z,
  input logic [CW-1:0] scalar_out,
  input logic degenerate,
  input logic saturated
);
`include "vector3_arithmetic_unit_assert.svh"
  `V3A_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x))
  `V3A_ASSERT_IMP(a_rdy, clk, rst_n, !out_valid, in_ready)
  `V3A_ASSERT_IMP(a_deg, clk, rst_n, out_valid && degenerate,
    out_x == '0 && out_y == '0 && out_z == '0 && scalar_out == '0 && !saturated)
endmodule

bind vector3_arithmetic_unit v3au_checker #(.CW(COMP_WIDTH)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_x(out_ch.out_x),
  .out_y(out_ch.out_y), .out_z(out_ch.out_z), .scalar_out(out_ch.scalar_out),
  .degenerate(out_ch.degenerate), .saturated(out_ch.saturated));
